FILE: rtl/oaid_pkg.sv
// Shared types and codes for the ordered array insert/delete block.
// No dependencies; imported by oaid_cell and ordered_array_insert_delete.
`timescale 1ns / 1ps

package oaid_pkg;

  // Field widths of the request and result words
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  // Position bus into the chain, wide enough for the largest supported depth (64)
  localparam int unsigned POS_BITS = 7;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_IDX   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DEL_IDX   = 3'd5;
  localparam logic [REQ_W-1:0] REQ_TRAVERSE  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  // Command to the chain: the operation and the position it applies at.
  // Insert loads at pos, delete removes pos, rotate wraps the head into pos.
  typedef struct packed {
    cell_op_e            op;
    logic [POS_BITS-1:0] pos;
  } cell_cmd_t;

endpackage

FILE: rtl/oaid_cell.sv
// One cell of the list chain: holds a single word and takes it from a neighbor.
// Depends on oaid_pkg for the chain command type.
`timescale 1ns / 1ps

module oaid_cell #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned IDX       = 0
) (
  input  logic                  clk_i,
  input  oaid_pkg::cell_cmd_t   cmd_i,
  input  logic [WORD_BITS-1:0]  new_word_i,
  input  logic [WORD_BITS-1:0]  left_i,
  input  logic [WORD_BITS-1:0]  right_i,
  input  logic [WORD_BITS-1:0]  wrap_i,
  output logic [WORD_BITS-1:0]  word_o
);
  import oaid_pkg::*;

  localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(IDX);

  logic [WORD_BITS-1:0] word_q;
  logic [WORD_BITS-1:0] word_d;

  // Pick the next word from the broadcast command and this cell's place
  always_comb begin
    word_d = word_q;
    unique case (cmd_i.op)
      CELL_HOLD: word_d = word_q;
      CELL_INSERT: begin
        if (MY_POS == cmd_i.pos) begin
          word_d = new_word_i;
        end else if (MY_POS > cmd_i.pos) begin
          word_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MY_POS >= cmd_i.pos) begin
          word_d = right_i;
        end
      end
      CELL_ROTATE: begin
        if (MY_POS == cmd_i.pos) begin
          word_d = wrap_i;
        end else begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

FILE: rtl/ordered_array_insert_delete.sv
// Top level of the ordered array insert/delete block: request decode, count,
// result register and the chain of oaid_cell instances. Depends on oaid_pkg.
`timescale 1ns / 1ps

// Keeps a packed list of up to DEPTH signed words in a chain of cells, one word
// per cell, plus an entry count. Every insert or delete request is carried out as
// it is accepted: all cells at or above the edit position move by one place in
// that same clock, and one status word carrying the new count is returned. A
// traverse request of n entries returns n words, one per cycle while the output
// is taken, with last set on the final one; the chain rotates by one place per
// word so that the head cell always feeds the output, and the list is back in
// order when the last word leaves. A traverse therefore occupies the block until
// its last word is loaded into the result register, during which no request is
// taken; an empty traverse returns a single word at once. Rejected edits (full,
// empty, index out of range) leave the list untouched. The result register lets
// a request be accepted while the previous result word is being taken.
module ordered_array_insert_delete #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic        [oaid_pkg::REQ_W-1:0]    req_type_i,
  input  logic        [oaid_pkg::IDX_W-1:0]    index_i,
  input  logic signed [oaid_pkg::VALUE_W-1:0]  value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [oaid_pkg::DATA_W-1:0]   data_o,
  output logic        [oaid_pkg::STATUS_W-1:0] status_o,
  output logic        [oaid_pkg::COUNT_W-1:0]  count_o,
  output logic                                 last_o
);
  import oaid_pkg::*;

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CW > IDX_W) ? CW : IDX_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TRAV = 1'b1;

  logic                 state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        trav_q, trav_d;

  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    data_q, data_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [COUNT_W-1:0]   cnt_out_q, cnt_out_d;
  logic                 last_q, last_d;

  logic                 in_fire;
  logic                 out_free;
  logic [CMP_W-1:0]     idx_w, cnt_w;
  logic                 full, empty;

  cell_cmd_t            cmd;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] words [DEPTH];

  logic signed [63:0]          val_ext;
  logic signed [WORD_BITS-1:0] head_s;
  logic signed [63:0]          head_ext;

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign idx_w = CMP_W'(index_i);
  assign cnt_w = CMP_W'(count_q);
  assign full  = (cnt_w == CMP_W'(DEPTH));
  assign empty = (count_q == '0);

  // Word conversions between the 32-bit ports and the stored width
  assign val_ext  = 64'(value_i);
  assign new_word = val_ext[WORD_BITS-1:0];
  assign head_s   = words[0];
  assign head_ext = 64'(head_s);

  // Decode requests, step the traverse and load the result register
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    trav_d      = trav_q;
    out_valid_d = out_valid_q && !out_ready_i;
    data_d      = data_q;
    status_d    = status_q;
    cnt_out_d   = cnt_out_q;
    last_d      = last_q;
    cmd.op      = CELL_HOLD;
    cmd.pos     = '0;

    if (state_q == ST_TRAV) begin
      if (out_free) begin
        out_valid_d = 1'b1;
        data_d      = head_ext[DATA_W-1:0];
        status_d    = STAT_OK;
        cnt_out_d   = COUNT_W'(cnt_w);
        last_d      = (trav_q == count_q - CW'(1));
        cmd.op      = CELL_ROTATE;
        cmd.pos     = POS_BITS'(cnt_w - CMP_W'(1));
        trav_d      = trav_q + CW'(1);
        if (trav_q == count_q - CW'(1)) begin
          state_d = ST_IDLE;
        end
      end
    end else if (in_fire) begin
      out_valid_d = 1'b1;
      data_d      = '0;
      status_d    = STAT_OK;
      last_d      = 1'b1;
      unique case (req_type_i)
        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_IDX: begin
          if (full) begin
            status_d = STAT_FULL;
          end else if (req_type_i == REQ_INS_IDX && idx_w > cnt_w) begin
            status_d = STAT_RANGE;
          end else begin
            cmd.op = CELL_INSERT;
            if (req_type_i == REQ_INS_FRONT) begin
              cmd.pos = '0;
            end else if (req_type_i == REQ_INS_BACK) begin
              cmd.pos = POS_BITS'(cnt_w);
            end else begin
              cmd.pos = POS_BITS'(idx_w);
            end
            count_d = count_q + CW'(1);
          end
        end
        REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_IDX: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else if (req_type_i == REQ_DEL_IDX && idx_w >= cnt_w) begin
            status_d = STAT_RANGE;
          end else begin
            cmd.op = CELL_DELETE;
            if (req_type_i == REQ_DEL_FRONT) begin
              cmd.pos = '0;
            end else if (req_type_i == REQ_DEL_BACK) begin
              cmd.pos = POS_BITS'(cnt_w - CMP_W'(1));
            end else begin
              cmd.pos = POS_BITS'(idx_w);
            end
            count_d = count_q - CW'(1);
          end
        end
        REQ_TRAVERSE: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            // Hand the words out from the traverse state on
            out_valid_d = out_valid_q && !out_ready_i;
            state_d     = ST_TRAV;
            trav_d      = '0;
          end
        end
        default: begin
          // Unused code: drop it without a result
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
      cnt_out_d = COUNT_W'(CMP_W'(count_d));
    end
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      trav_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      trav_q      <= trav_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    status_q  <= status_d;
    cnt_out_q <= cnt_out_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = data_q;
  assign status_o    = status_q;
  assign count_o     = cnt_out_q;
  assign last_o      = last_q;

  // Chain of cells; the ends feed back their own word where no neighbor exists
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    oaid_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .new_word_i (new_word),
      .left_i     (left_w),
      .right_i    (right_w),
      .wrap_i     (words[0]),
      .word_o     (words[i])
    );
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= CMP_W'(DEPTH))
    else $error("entry count above depth");

  a_trav_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && state_d == ST_TRAV) |-> !empty)
    else $error("traverse started on an empty list");

  a_trav_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRAV) |=> $stable(count_q))
    else $error("count changed during traverse");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == CELL_INSERT) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count");

  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == CELL_DELETE) |=> (count_q == $past(count_q) - CW'(1)))
    else $error("delete did not shrink the count");

endmodule
